>>> src/text_console_char_engine_top_assert.svh
// Assertion macros shared by the text console character engine RTL.
// Included by the files that carry concurrent checks; no other dependency.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define TCCE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcce assertion failed");

// cond must never be true outside reset
`define TCCE_ASSERT_NEVER(name, clk, rst_n, cond) \
  `TCCE_ASSERT(name, clk, rst_n, !(cond))

`else

`define TCCE_ASSERT(name, clk, rst_n, prop)
`define TCCE_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

>>> src/tcce_pkg.sv
// Shared types and constants of the text console character engine.
// No dependencies; imported by the top level, front end, queue and back end.
`default_nettype none

package tcce_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [7:0] NORMAL_ATTR_RST = 8'h07;
  localparam logic [7:0] BRIGHT_ATTR_RST = 8'h0F;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_ATTR = 1'b0,
    CFG_BRIGHT_ATTR = 1'b1
  } cfg_reg_e;

  // Column field of a queued operation; holds any column up to 256 columns
  localparam int OP_COL_W = 8;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_NEWLINE  = 3'd2,
    OP_NL_WRITE = 3'd3,
    OP_READ     = 3'd4
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [OP_COL_W-1:0]   col;
    logic [7:0]            char_code;
    logic [7:0]            attr;
    logic [4:0]            read_row;
    logic [6:0]            read_column;
    logic [6:0]            cursor_column;
  } op_t;

endpackage

`default_nettype wire

>>> src/tcce_in_if.sv
// Input channel of the text console character engine: valid/ready plus item.
// Depends on nothing beyond the port widths fixed here.
`default_nettype none

interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_column;

  modport source (output valid, output cmd, output char_code, output read_row,
                  output read_column, input ready);
  modport sink   (input valid, input cmd, input char_code, input read_row,
                  input read_column, output ready);
endinterface

`default_nettype wire

>>> src/tcce_out_if.sv
// Result channel of the text console character engine: valid/ready plus cell.
// Depends on nothing beyond the port widths fixed here.
`default_nettype none

interface tcce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [6:0] cursor_column;

  modport source (output valid, output cell_char, output cell_attr,
                  output cursor_column, input ready);
  modport sink   (input valid, input cell_char, input cell_attr,
                  input cursor_column, output ready);
endinterface

`default_nettype wire

>>> src/text_console_char_engine_top.sv
// Top level of the text console character engine.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if, tcce_front, tcce_queue, tcce_back.
`default_nettype none

// Keeps a ROWS x COLUMNS text screen (character and attribute byte per cell) and
// returns one result beat for every input beat. After reset the screen memory is
// cleared one cell a cycle while in_i.ready stays low; configuration writes are
// taken throughout. The front end parses each character in the cycle it is
// accepted and hands an operation to a two-entry queue; the back end works it
// against the single-port screen memory. Escape bytes, carriage return and tab
// go straight to the result; a printed character first writes its cell; a cell
// read passes through row offset, address wrap, memory read and result; a newline
// or a wrapping character first clears the new bottom row one cell a cycle.
// Scrolling itself only moves a row pointer.

module text_console_char_engine_top import tcce_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tcce_in_if.sink                    in_i,
  tcce_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  op_t  push_op, pop_op;
  logic push, pop, q_full, q_empty, init_busy;

  tcce_front #(
    .COLUMNS  (COLUMNS),
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .op_o        (push_op)
  );

  tcce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .op_o    (pop_op),
    .empty_o (q_empty)
  );

  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (pop_op),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> src/tcce_front.sv
// Front end: accepts items, runs the escape parser and cursor, emits screen ops.
// Depends on tcce_pkg, tcce_in_if and the assertion macro header.
`default_nettype none
`include "text_console_char_engine_top_assert.svh"

module tcce_front import tcce_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int TAB_STOP = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tcce_in_if.sink                    in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  q_full_i,
  input  wire logic                  init_busy_i,
  output logic                       push_o,
  output op_t                        op_o
);

  localparam int CUR_W = $clog2(COLUMNS + 1);
  localparam int PH_W  = $clog2(TAB_STOP);
  localparam int NW    = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int END_PHASE = COLUMNS % TAB_STOP;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_CSI  = 3'b100
  } esc_state_e;

  esc_state_e       esc_q, esc_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [PH_W-1:0]  phase_q, phase_d;   // cursor modulo TAB_STOP
  logic             nz_q, nz_d;
  logic             bright_q, bright_d;
  logic [7:0]       normal_attr_q, bright_attr_q;

  logic             ordinary;
  logic [NW-1:0]    tab_next;
  logic [7:0]       ch;
  logic             is_digit;

  assign ch       = in_i.char_code;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign tab_next = NW'(cursor_q) + NW'(TAB_STOP) - NW'(phase_q);

  assign in_i.ready = !q_full_i && !init_busy_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    esc_d     = esc_q;
    cursor_d  = cursor_q;
    phase_d   = phase_q;
    nz_d      = nz_q;
    bright_d  = bright_q;
    ordinary  = 1'b0;
    op_o.kind = OP_NONE;
    op_o.col  = OP_COL_W'(cursor_q);

    if (in_i.cmd) begin
      op_o.kind = OP_READ;
    end else begin
      case (esc_q)
        ESC_SEEN: begin
          if (ch == CH_LBRACKET) begin
            esc_d = ESC_CSI;
          end else begin
            esc_d    = ESC_IDLE;
            ordinary = 1'b1;
          end
        end
        ESC_CSI: begin
          if (is_digit) begin
            nz_d = nz_q || (ch != CH_ZERO);
          end else if (ch == CH_M) begin
            bright_d = nz_q;
            esc_d    = ESC_IDLE;
          end else begin
            esc_d    = ESC_IDLE;
            ordinary = 1'b1;
          end
        end
        default: begin
          esc_d    = ESC_IDLE;
          ordinary = 1'b1;
        end
      endcase

      if (ordinary) begin
        case (ch)
          CH_NL: begin
            op_o.kind = OP_NEWLINE;
            cursor_d  = '0;
            phase_d   = '0;
          end
          CH_CR: begin
            cursor_d = '0;
            phase_d  = '0;
          end
          CH_TAB: begin
            // saturate at the end of the line
            if (tab_next > NW'(COLUMNS)) begin
              cursor_d = CUR_W'(COLUMNS);
              phase_d  = PH_W'(END_PHASE);
            end else begin
              cursor_d = CUR_W'(tab_next);
              phase_d  = '0;
            end
          end
          CH_ESC: begin
            esc_d = ESC_SEEN;
            nz_d  = 1'b0;
          end
          default: begin
            if (cursor_q == CUR_W'(COLUMNS)) begin
              // wrap: scroll first, then write at column zero
              op_o.kind = OP_NL_WRITE;
              op_o.col  = '0;
              cursor_d  = CUR_W'(1);
              phase_d   = PH_W'(1);
            end else begin
              op_o.kind = OP_WRITE;
              cursor_d  = cursor_q + CUR_W'(1);
              phase_d   = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);
            end
          end
        endcase
      end
    end

    op_o.char_code     = ch;
    op_o.attr          = bright_q ? bright_attr_q : normal_attr_q;
    op_o.read_row      = in_i.read_row;
    op_o.read_column   = in_i.read_column;
    op_o.cursor_column = 7'(cursor_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= ESC_IDLE;
      cursor_q <= '0;
      phase_q  <= '0;
      nz_q     <= 1'b0;
      bright_q <= 1'b0;
    end else if (push_o) begin
      esc_q    <= esc_d;
      cursor_q <= cursor_d;
      phase_q  <= phase_d;
      nz_q     <= nz_d;
      bright_q <= bright_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_attr_q <= NORMAL_ATTR_RST;
      bright_attr_q <= BRIGHT_ATTR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NORMAL_ATTR: normal_attr_q <= cfg_wdata_i;
        CFG_BRIGHT_ATTR: bright_attr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  `TCCE_ASSERT(a_cursor_in_line, clk_i, rst_ni, cursor_q <= CUR_W'(COLUMNS))

endmodule

`default_nettype wire

>>> src/tcce_queue.sv
// Short operation queue between the front end and the screen back end.
// Depends on tcce_pkg for the operation type and depth.
`default_nettype none
`include "text_console_char_engine_top_assert.svh"

module tcce_queue import tcce_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output op_t       op_o,
  output logic      empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign op_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `TCCE_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `TCCE_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

`default_nettype wire

>>> src/tcce_back.sv
// Back end: owns the screen memory, executes queued ops, holds the result beat.
// Depends on tcce_pkg, tcce_out_if and the assertion macro header.
`default_nettype none
`include "text_console_char_engine_top_assert.svh"

module tcce_back import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire op_t  op_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      init_busy_o,
  tcce_out_if.source out_o
);

  localparam int TOTAL     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(TOTAL);
  localparam int SUM_W     = ADDR_W + 1;
  localparam int COL_IDX_W = $clog2(COLUMNS);

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CLEAR   = 8'b0000_0100,
    ST_WRITE   = 8'b0000_1000,
    ST_RD_MUL  = 8'b0001_0000,
    ST_RD_ADDR = 8'b0010_0000,
    ST_RD_MEM  = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } back_state_e;

  back_state_e          state_q, state_d;
  op_t                  op_q;
  logic [ADDR_W-1:0]    top_base_q, top_base_d;  // address of screen row 0
  logic [ADDR_W-1:0]    bot_base_q, bot_base_d;  // address of the bottom row
  logic [ADDR_W-1:0]    init_cnt_q, init_cnt_d;
  logic [COL_IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [ADDR_W-1:0]    row_off_q;
  logic                 rd_hit_q;
  logic [ADDR_W-1:0]    rd_addr_q;
  logic [15:0]          rd_data_q;
  logic [15:0]          mem_q [TOTAL];

  logic                 out_valid_q;
  logic [7:0]           out_char_q, out_attr_q;
  logic [6:0]           out_cur_q;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [15:0]          mem_wdata;
  logic [ADDR_W-1:0]    top_adv;
  logic [SUM_W-1:0]     rd_sum, rd_wrap;
  logic                 out_load;

  assign init_busy_o = (state_q == ST_INIT);
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign top_adv = (top_base_q == ADDR_W'(TOTAL - COLUMNS)) ? '0
                                                             : top_base_q + ADDR_W'(COLUMNS);

  assign rd_sum  = SUM_W'(top_base_q) + SUM_W'(row_off_q) + SUM_W'(op_q.read_column);
  assign rd_wrap = (rd_sum >= SUM_W'(TOTAL)) ? rd_sum - SUM_W'(TOTAL) : rd_sum;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bot_base_q + ADDR_W'(op_q.col);
    mem_wdata = '0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt_q;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = bot_base_q + ADDR_W'(clr_cnt_q);
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {op_q.attr, op_q.char_code};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    top_base_d = top_base_q;
    bot_base_d = bot_base_q;
    init_cnt_d = init_cnt_q;
    clr_cnt_d  = clr_cnt_q;
    case (state_q)
      ST_INIT: begin
        init_cnt_d = init_cnt_q + ADDR_W'(1);
        if (init_cnt_q == ADDR_W'(TOTAL - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          case (op_i.kind)
            OP_WRITE: state_d = ST_WRITE;
            OP_NEWLINE, OP_NL_WRITE: begin
              // scroll: old top row becomes the new bottom row
              top_base_d = top_adv;
              bot_base_d = top_base_q;
              clr_cnt_d  = '0;
              state_d    = ST_CLEAR;
            end
            OP_READ: state_d = ST_RD_MUL;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + COL_IDX_W'(1);
        if (clr_cnt_q == COL_IDX_W'(COLUMNS - 1)) begin
          state_d = (op_q.kind == OP_NL_WRITE) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE:   state_d = ST_DONE;
      ST_RD_MUL:  state_d = ST_RD_ADDR;
      ST_RD_ADDR: state_d = ST_RD_MEM;
      ST_RD_MEM:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      top_base_q <= '0;
      bot_base_q <= ADDR_W'(TOTAL - COLUMNS);
      init_cnt_q <= '0;
      clr_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      top_base_q <= top_base_d;
      bot_base_q <= bot_base_d;
      init_cnt_q <= init_cnt_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Payload and read pipeline
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= op_i;
    end
    if (state_q == ST_RD_MUL) begin
      row_off_q <= ADDR_W'(ADDR_W'(op_q.read_row) * ADDR_W'(COLUMNS));
      rd_hit_q  <= (int'(op_q.read_row) < ROWS) && (int'(op_q.read_column) < COLUMNS);
    end
    if (state_q == ST_RD_ADDR) begin
      rd_addr_q <= ADDR_W'(rd_wrap);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_RD_MEM) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  // Result register: hold the beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if ((op_q.kind == OP_READ) && rd_hit_q) begin
        out_char_q <= rd_data_q[7:0];
        out_attr_q <= rd_data_q[15:8];
      end else begin
        out_char_q <= '0;
        out_attr_q <= '0;
      end
      out_cur_q <= op_q.cursor_column;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_char     = out_char_q;
  assign out_o.cell_attr     = out_attr_q;
  assign out_o.cursor_column = out_cur_q;

  `TCCE_ASSERT(a_row_bases_apart, clk_i, rst_ni,
               (top_base_q != bot_base_q) && (top_base_q <= ADDR_W'(TOTAL - COLUMNS)))
  `TCCE_ASSERT(a_clear_in_row, clk_i, rst_ni,
               (state_q == ST_CLEAR) |-> (clr_cnt_q <= COL_IDX_W'(COLUMNS - 1)))

endmodule

`default_nettype wire
